@@ hw/rtl/srs_pkg.sv @@
// shared types and constants for the sensor reading statistics block
`timescale 1ns / 1ps

package srs_pkg;

  localparam int REG_W       = 15;
  localparam int READING_W   = 16;
  localparam int CNT_W       = 8;
  localparam int IDX_W       = 7;
  localparam int SUM_W       = 23;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_HIGH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_LOW  = 3'd5;

  localparam logic [REG_W-1:0] RST_NORMAL_HIGH   = 15'd464;
  localparam logic [REG_W-1:0] RST_WARNING_LOW   = 15'd480;
  localparam logic [REG_W-1:0] RST_WARNING_HIGH  = 15'd704;
  localparam logic [REG_W-1:0] RST_CRITICAL_LOW  = 15'd720;
  localparam logic [REG_W-1:0] RST_CRITICAL_HIGH = 15'd944;
  localparam logic [REG_W-1:0] RST_SHUTDOWN_LOW  = 15'd960;

  localparam logic [IDX_W-1:0] IDX_SAT = 7'd127;

  typedef enum logic [2:0] {
    BAND_NORMAL,
    BAND_WARNING,
    BAND_CRITICAL,
    BAND_SHUTDOWN,
    BAND_NONE
  } band_t;

  typedef struct packed {
    logic signed [READING_W-1:0] reading;
    logic                        last;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] valid_count;
    logic [CNT_W-1:0] skipped_count;
    logic             critical_found;
    logic [IDX_W-1:0] first_critical_index;
    logic [REG_W-1:0] min_reading;
    logic [REG_W-1:0] max_reading;
    logic [REG_W-1:0] avg_reading;
    logic [CNT_W-1:0] normal_total;
    logic [CNT_W-1:0] warning_total;
    logic [CNT_W-1:0] critical_total;
    logic [CNT_W-1:0] shutdown_total;
  } out_word_t;

  // classified reading handed from front to back
  typedef struct packed {
    logic             err;
    logic [REG_W-1:0] value;
    band_t            band;
    logic             crit_hit;
    logic             last;
  } cls_word_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

@@ hw/rtl/srs_front.sv @@
// front end: threshold registers and reading classification
`timescale 1ns / 1ps

module srs_front
  import srs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  input  logic                 q_full,
  output logic                 q_push,
  output cls_word_t            q_wdata
);

  logic [REG_W-1:0] normal_high_r;
  logic [REG_W-1:0] warning_low_r;
  logic [REG_W-1:0] warning_high_r;
  logic [REG_W-1:0] critical_low_r;
  logic [REG_W-1:0] critical_high_r;
  logic [REG_W-1:0] shutdown_low_r;
  logic [REG_W-1:0] value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_high_r   <= RST_NORMAL_HIGH;
      warning_low_r   <= RST_WARNING_LOW;
      warning_high_r  <= RST_WARNING_HIGH;
      critical_low_r  <= RST_CRITICAL_LOW;
      critical_high_r <= RST_CRITICAL_HIGH;
      shutdown_low_r  <= RST_SHUTDOWN_LOW;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NORMAL_HIGH:   normal_high_r   <= cfg_wdata;
        REG_WARNING_LOW:   warning_low_r   <= cfg_wdata;
        REG_WARNING_HIGH:  warning_high_r  <= cfg_wdata;
        REG_CRITICAL_LOW:  critical_low_r  <= cfg_wdata;
        REG_CRITICAL_HIGH: critical_high_r <= cfg_wdata;
        REG_SHUTDOWN_LOW:  shutdown_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign value    = in_word.reading[REG_W-1:0];
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.err      = in_word.reading[READING_W-1];
    q_wdata.value    = value;
    q_wdata.crit_hit = (value >= critical_low_r);
    q_wdata.last     = in_word.last;
    // first matching band wins, gaps fall through to none
    if (value <= normal_high_r) begin
      q_wdata.band = BAND_NORMAL;
    end else if (value >= warning_low_r && value <= warning_high_r) begin
      q_wdata.band = BAND_WARNING;
    end else if (value >= critical_low_r && value <= critical_high_r) begin
      q_wdata.band = BAND_CRITICAL;
    end else if (value >= shutdown_low_r) begin
      q_wdata.band = BAND_SHUTDOWN;
    end else begin
      q_wdata.band = BAND_NONE;
    end
  end

endmodule

@@ hw/rtl/srs_queue.sv @@
// short queue of classified words between front and back
`timescale 1ns / 1ps

module srs_queue
  import srs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_word_t wdata,
  output logic      full,
  input  logic      pop,
  output logic      rvalid,
  output cls_word_t rdata
);

  cls_word_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_pop;

  assign full   = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = mem[rd_ptr_r];
  assign do_pop = pop && rvalid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ hw/rtl/srs_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module srs_div
  import srs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] steps_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    rem_sh;
  logic              fits;
  logic [CNT_W:0]    rem_sub;

  assign rem_sh   = {rem_r, quo_r[SUM_W-1]};
  assign fits     = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      steps_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        steps_r <= STEP_W'(SUM_W);
        quo_r   <= req.dividend;
        dvs_r   <= req.divisor;
        rem_r   <= '0;
      end else if (busy_r) begin
        quo_r   <= {quo_r[SUM_W-2:0], fits};
        rem_r   <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        steps_r <= steps_r - 1'b1;
        if (steps_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/srs_back.sv @@
// back end: batch accumulation, batch-end average and result register
`timescale 1ns / 1ps

module srs_back
  import srs_pkg::*;
#(
  parameter int CNT_LIMIT = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cls_word_t        q_word,
  output logic             q_pop,
  output div_req_t         div_req,
  input  logic             div_done,
  input  logic [SUM_W-1:0] div_quotient,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word
);

  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(CNT_LIMIT);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV,
    ST_SEND
  } state_t;

  state_t           state_r,    state_nxt;
  logic [CNT_W-1:0] seen_r,     seen_nxt;
  logic [CNT_W-1:0] acc_r,      acc_nxt;
  logic [CNT_W-1:0] err_r,      err_nxt;
  logic             found_r,    found_nxt;
  logic [IDX_W-1:0] first_r,    first_nxt;
  logic [REG_W-1:0] min_r,      min_nxt;
  logic [REG_W-1:0] max_r,      max_nxt;
  logic [SUM_W-1:0] sum_r,      sum_nxt;
  logic [CNT_W-1:0] band_r [4];
  logic [CNT_W-1:0] band_nxt [4];
  out_word_t        snap_r,     snap_nxt;
  out_word_t        out_word_r, out_word_nxt;
  logic             out_valid_r, out_valid_nxt;

  // values after folding in the word at the head of the queue
  logic [CNT_W-1:0] seen_u, acc_u, err_u;
  logic             found_u;
  logic [IDX_W-1:0] first_u;
  logic [REG_W-1:0] min_u, max_u;
  logic [SUM_W-1:0] sum_u;
  logic [CNT_W-1:0] band_u [4];
  logic             out_free;

  assign q_pop     = (state_r == ST_ACCUM) && q_valid;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    seen_u  = seen_r;
    acc_u   = acc_r;
    err_u   = err_r;
    found_u = found_r;
    first_u = first_r;
    min_u   = min_r;
    max_u   = max_r;
    sum_u   = sum_r;
    for (int i = 0; i < 4; i++) begin
      band_u[i] = band_r[i];
    end
    // once the batch is full only the last flag matters
    if (seen_r < LIMIT_C) begin
      seen_u = seen_r + 1'b1;
      if (q_word.err) begin
        err_u = err_r + 1'b1;
      end else begin
        if (acc_r == '0 || q_word.value < min_r) begin
          min_u = q_word.value;
        end
        if (acc_r == '0 || q_word.value > max_r) begin
          max_u = q_word.value;
        end
        sum_u = sum_r + SUM_W'(q_word.value);
        if (!found_r && q_word.crit_hit) begin
          found_u = 1'b1;
          first_u = (acc_r > CNT_W'(IDX_SAT)) ? IDX_SAT : acc_r[IDX_W-1:0];
        end
        case (q_word.band)
          BAND_NORMAL:   band_u[0] = band_r[0] + 1'b1;
          BAND_WARNING:  band_u[1] = band_r[1] + 1'b1;
          BAND_CRITICAL: band_u[2] = band_r[2] + 1'b1;
          BAND_SHUTDOWN: band_u[3] = band_r[3] + 1'b1;
          default: ;
        endcase
        acc_u = acc_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    found_nxt     = found_r;
    first_nxt     = first_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    for (int i = 0; i < 4; i++) begin
      band_nxt[i] = band_r[i];
    end
    snap_nxt      = snap_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_req.start    = 1'b0;
    div_req.dividend = sum_u;
    div_req.divisor  = acc_u;

    case (state_r)
      ST_ACCUM: begin
        if (q_valid) begin
          if (q_word.last) begin
            snap_nxt.total_count          = seen_u;
            snap_nxt.valid_count          = acc_u;
            snap_nxt.skipped_count        = err_u;
            snap_nxt.critical_found       = found_u;
            snap_nxt.first_critical_index = first_u;
            snap_nxt.min_reading          = min_u;
            snap_nxt.max_reading          = max_u;
            snap_nxt.avg_reading          = '0;
            snap_nxt.normal_total         = band_u[0];
            snap_nxt.warning_total        = band_u[1];
            snap_nxt.critical_total       = band_u[2];
            snap_nxt.shutdown_total       = band_u[3];
            div_req.start = 1'b1;
            seen_nxt  = '0;
            acc_nxt   = '0;
            err_nxt   = '0;
            found_nxt = 1'b0;
            first_nxt = '0;
            min_nxt   = '0;
            max_nxt   = '0;
            sum_nxt   = '0;
            for (int i = 0; i < 4; i++) begin
              band_nxt[i] = '0;
            end
            state_nxt = ST_DIV;
          end else begin
            seen_nxt  = seen_u;
            acc_nxt   = acc_u;
            err_nxt   = err_u;
            found_nxt = found_u;
            first_nxt = first_u;
            min_nxt   = min_u;
            max_nxt   = max_u;
            sum_nxt   = sum_u;
            for (int i = 0; i < 4; i++) begin
              band_nxt[i] = band_u[i];
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // empty batch averages to zero
          snap_nxt.avg_reading = (snap_r.valid_count == '0) ? '0 : div_quotient[REG_W-1:0];
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_free) begin
          out_word_nxt  = snap_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_ACCUM;
        end
      end
      default: state_nxt = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      seen_r      <= '0;
      acc_r       <= '0;
      err_r       <= '0;
      found_r     <= 1'b0;
      first_r     <= '0;
      min_r       <= '0;
      max_r       <= '0;
      sum_r       <= '0;
      for (int i = 0; i < 4; i++) begin
        band_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      acc_r       <= acc_nxt;
      err_r       <= err_nxt;
      found_r     <= found_nxt;
      first_r     <= first_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      for (int i = 0; i < 4; i++) begin
        band_r[i] <= band_nxt[i];
      end
      out_valid_r <= out_valid_nxt;
    end
    snap_r     <= snap_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

@@ hw/rtl/sensor_reading_statistics.sv @@
// top level of the sensor reading statistics block
//
// readings enter on in_valid/in_stall/in_word, one word per cycle while the
// four-entry queue has room; a word is taken when in_valid is high and
// in_stall is low. the front classifies each reading against the six
// threshold registers (cfg_we/cfg_index/cfg_wdata, writes to indexes above
// five are dropped) and the back folds it into the batch totals.
// a word with last set closes the batch: the 23-step restoring divider
// forms the average, and the summary then appears on out_valid/out_word.
// inside a batch the rate is one reading per cycle; each batch end holds
// the back while the average is formed and the summary is sent, during
// which the queue fills and then stalls the input.
// the summary sits in an output register until out_stall is low; while it
// waits the back keeps draining the queue up to the next batch end.
// reset (rst_n low, synchronous) restores the threshold defaults, clears
// the batch totals and empties the queue and the output register.
`timescale 1ns / 1ps

module sensor_reading_statistics
  import srs_pkg::*;
#(
  parameter int MAX_READINGS = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word
);

  localparam int COUNT_LIMIT = (MAX_READINGS < 255) ? MAX_READINGS : 255;

  logic             q_full;
  logic             q_push;
  cls_word_t        q_wdata;
  logic             q_pop;
  logic             q_valid;
  cls_word_t        q_rdata;
  div_req_t         div_req;
  logic             div_done;
  logic [SUM_W-1:0] div_quotient;

  srs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  srs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  srs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quotient)
  );

  srs_back #(
    .CNT_LIMIT (COUNT_LIMIT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_word       (q_rdata),
    .q_pop        (q_pop),
    .div_req      (div_req),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word)
  );

endmodule
